// ===== rtl/ive_pkg.sv =====
// Package with the shared constants and types of the indel variant enumerator.
`timescale 1ns / 1ps
`default_nettype none

package ive_pkg;

    // Largest barcode length and the symbol alphabet.
    localparam int MAX_CODE_LEN  = 32;
    localparam int ALPHABET_SIZE = 4;
    localparam int STORE_DEPTH   = MAX_CODE_LEN + 1;

    localparam int SYM_W     = 2;
    localparam int LEN_W     = 6;
    localparam int VARIANT_W = 2 * MAX_CODE_LEN;

    localparam logic [LEN_W-1:0] CODE_LEN_RESET = LEN_W'(8);

    // Edit kinds reported with a candidate.
    localparam logic EDIT_DELETE = 1'b0;
    localparam logic EDIT_INSERT = 1'b1;

    // Request types of an input word.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_NEXT = 1'b1;

    // Status of the read held in the store.
    typedef struct packed {
        logic             valid;
        logic             idle;
        logic [LEN_W-1:0] len;
    } t_read_status;

    // One result word.
    typedef struct packed {
        logic                 has_variant;
        logic [VARIANT_W-1:0] variant;
        logic [LEN_W-1:0]     edit_pos;
        logic                 edit_kind;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/ive_read_store.sv =====
// Read store: holds the loaded read symbols and tracks the read length and validity.
`timescale 1ns / 1ps
`default_nettype none

module ive_read_store (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_load,
    input  wire logic [ive_pkg::SYM_W-1:0]           i_symbol,
    input  wire logic                                i_last_symbol,
    output logic [ive_pkg::SYM_W*ive_pkg::STORE_DEPTH-1:0] o_store,
    output ive_pkg::t_read_status                    o_status
);
    import ive_pkg::*;

    localparam int IDX_W = $clog2(STORE_DEPTH);

    logic [SYM_W-1:0] r_store [STORE_DEPTH];
    logic [LEN_W-1:0] r_count, n_count;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_valid, n_valid;
    logic             r_bad, n_bad;
    logic             room;
    logic [IDX_W-1:0] wr_idx;

    assign room   = (r_count < LEN_W'(STORE_DEPTH));
    assign wr_idx = r_count[IDX_W-1:0];

    // Symbol row: written at the fill position, no reset.
    always_ff @(posedge i_clk) begin
        if (i_load && room) begin
            r_store[wr_idx] <= i_symbol;
        end
    end

    // Load bookkeeping for the read being assembled.
    always_comb begin
        n_count = r_count;
        n_len   = r_len;
        n_valid = r_valid;
        n_bad   = r_bad;
        if (i_load) begin
            if (r_count == '0) begin
                n_valid = 1'b0;
                n_bad   = 1'b0;
            end
            if (int'(i_symbol) >= ALPHABET_SIZE) begin
                n_bad = 1'b1;
            end
            if (room) begin
                n_count = r_count + LEN_W'(1);
            end else begin
                n_bad = 1'b1;
            end
            if (i_last_symbol) begin
                n_len   = n_count;
                n_valid = !n_bad;
                n_count = '0;
                n_bad   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_len   <= '0;
            r_valid <= 1'b0;
            r_bad   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_len   <= n_len;
            r_valid <= n_valid;
            r_bad   <= n_bad;
        end
    end

    // Flatten the row for the candidate builder.
    for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_flat
        assign o_store[SYM_W*g +: SYM_W] = r_store[g];
    end

    assign o_status.valid = r_valid;
    assign o_status.idle  = (r_count == '0);
    assign o_status.len   = r_len;

endmodule

`default_nettype wire

// ===== rtl/ive_cand_gen.sv =====
// Candidate builder: edit cursor, insert symbol and the per-position symbol select.
`timescale 1ns / 1ps
`default_nettype none

module ive_cand_gen (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_step,
    input  wire logic                                i_restart,
    input  wire logic [ive_pkg::LEN_W-1:0]           i_code_len,
    input  wire ive_pkg::t_read_status               i_status,
    input  wire logic [ive_pkg::SYM_W*ive_pkg::STORE_DEPTH-1:0] i_store,
    output ive_pkg::t_result                         o_result
);
    import ive_pkg::*;

    localparam int INS_W = $clog2(ALPHABET_SIZE + 1);

    logic [LEN_W-1:0]     r_cursor, n_cursor;
    logic [SYM_W-1:0]     r_ins, n_ins;
    logic                 usable;
    logic [LEN_W:0]       len_ext;
    logic [LEN_W:0]       rlen_ext;
    logic                 del_mode, ins_mode;
    logic                 del_go, ins_go;
    logic [VARIANT_W-1:0] del_word, ins_word;
    logic [INS_W-1:0]     ins_inc;

    assign len_ext  = {1'b0, i_code_len};
    assign rlen_ext = {1'b0, i_status.len};
    assign usable   = i_status.valid && i_status.idle && (i_code_len != '0)
                      && (i_code_len <= LEN_W'(MAX_CODE_LEN));
    assign del_mode = usable && (rlen_ext == len_ext + (LEN_W+1)'(1));
    assign ins_mode = usable && (rlen_ext + (LEN_W+1)'(1) == len_ext);
    assign del_go   = del_mode && (r_cursor < i_status.len);
    assign ins_go   = ins_mode && (r_cursor < i_code_len);

    // Per-position symbol select for both edit kinds.
    for (genvar g = 0; g < MAX_CODE_LEN; g++) begin : g_pos
        logic in_len;
        logic lower;
        logic at;
        assign in_len = (LEN_W'(g) < i_code_len);
        assign lower  = (LEN_W'(g) < r_cursor);
        assign at     = (LEN_W'(g) == r_cursor);

        assign del_word[SYM_W*g +: SYM_W] = !in_len ? '0 :
            lower ? i_store[SYM_W*g +: SYM_W] : i_store[SYM_W*(g+1) +: SYM_W];

        if (g == 0) begin : g_first
            assign ins_word[SYM_W*g +: SYM_W] = !in_len ? '0 :
                lower ? i_store[SYM_W*g +: SYM_W] : r_ins;
        end else begin : g_rest
            assign ins_word[SYM_W*g +: SYM_W] = !in_len ? '0 :
                lower ? i_store[SYM_W*g +: SYM_W] :
                at    ? r_ins : i_store[SYM_W*(g-1) +: SYM_W];
        end
    end

    // Result word for the current cursor.
    always_comb begin
        o_result = '0;
        if (del_go) begin
            o_result.has_variant = 1'b1;
            o_result.variant     = del_word;
            o_result.edit_pos    = r_cursor;
            o_result.edit_kind   = EDIT_DELETE;
        end else if (ins_go) begin
            o_result.has_variant = 1'b1;
            o_result.variant     = ins_word;
            o_result.edit_pos    = r_cursor;
            o_result.edit_kind   = EDIT_INSERT;
        end
    end

    // Cursor advance: one position per deletion, one per full alphabet sweep.
    assign ins_inc = INS_W'(r_ins) + INS_W'(1);

    always_comb begin
        n_cursor = r_cursor;
        n_ins    = r_ins;
        if (i_restart) begin
            n_cursor = '0;
            n_ins    = '0;
        end else if (i_step && del_go) begin
            n_cursor = r_cursor + LEN_W'(1);
        end else if (i_step && ins_go) begin
            if (int'(ins_inc) >= ALPHABET_SIZE) begin
                n_ins    = '0;
                n_cursor = r_cursor + LEN_W'(1);
            end else begin
                n_ins = ins_inc[SYM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_ins    <= '0;
        end else begin
            r_cursor <= n_cursor;
            r_ins    <= n_ins;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/indel_variant_enumerator.sv =====
// Top level of the indel variant enumerator: handshakes, code_len register, result register.
// A candidate word is registered and appears in the cycle after its request is accepted.
// Throughput: one word per cycle while the output is not stalled; loads and requests share the input.
// The rate is set by the single result register behind the candidate select.
// Reset (synchronous, active low) clears the read status, cursor and output valid;
// code_len returns to 8. The symbol store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module indel_variant_enumerator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_code_len_we,
    input  wire logic [ive_pkg::LEN_W-1:0]       i_code_len_wdata,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_req_type,
    input  wire logic [ive_pkg::SYM_W-1:0]       i_symbol,
    input  wire logic                            i_last_symbol,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic                                 o_has_variant,
    output logic [ive_pkg::VARIANT_W-1:0]        o_variant,
    output logic [ive_pkg::LEN_W-1:0]            o_edit_pos,
    output logic                                 o_edit_kind
);
    import ive_pkg::*;

    logic [LEN_W-1:0]             r_code_len;
    logic                         r_out_valid;
    t_result                      r_out;
    logic                         accept;
    logic                         do_load;
    logic                         do_req;
    logic [SYM_W*STORE_DEPTH-1:0] store_row;
    t_read_status                 status;
    t_result                      cand;

    // Input handshake: the output register frees itself when its word is taken.
    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign do_load = accept && (i_req_type == REQ_LOAD);
    assign do_req  = accept && (i_req_type == REQ_NEXT);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_len <= CODE_LEN_RESET;
        end else if (i_code_len_we) begin
            r_code_len <= i_code_len_wdata;
        end
    end

    ive_read_store u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (do_load),
        .i_symbol      (i_symbol),
        .i_last_symbol (i_last_symbol),
        .o_store       (store_row),
        .o_status      (status)
    );

    ive_cand_gen u_cand (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (do_req),
        .i_restart  (do_load && i_last_symbol),
        .i_code_len (r_code_len),
        .i_status   (status),
        .i_store    (store_row),
        .o_result   (cand)
    );

    // Output register: valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_req) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register: result word.
    always_ff @(posedge i_clk) begin
        if (do_req) begin
            r_out <= cand;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_has_variant = r_out.has_variant;
    assign o_variant     = r_out.variant;
    assign o_edit_pos    = r_out.edit_pos;
    assign o_edit_kind   = r_out.edit_kind;

endmodule

`default_nettype wire
